// ===== rtl/exact_int_float_converter_assert.svh =====
`ifndef EXACT_INT_FLOAT_CONVERTER_ASSERT_SVH
`define EXACT_INT_FLOAT_CONVERTER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define EICF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eicf check failed");

// next-cycle implication, off while reset is high
`define EICF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eicf check failed");

// next-cycle implication, always on
`define EICF_ASSERT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("eicf check failed");

`endif

// ===== rtl/eicf_pkg.sv =====
package eicf_pkg;

   localparam int WordWidth   = 32;
   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 3;

   localparam logic [ModeWidth-1:0] MODE_INT_TO_FLOAT = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_FLOAT_TO_INT = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_POS_FINITE   = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_RANGE        = 2'd3;

   localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
   localparam logic [StatusWidth-1:0] ST_TOO_LARGE = 3'd1;
   localparam logic [StatusWidth-1:0] ST_NEG_ZERO  = 3'd2;
   localparam logic [StatusWidth-1:0] ST_NEGATIVE  = 3'd3;
   localparam logic [StatusWidth-1:0] ST_NOT_FIN   = 3'd4;
   localparam logic [StatusWidth-1:0] ST_DENORMAL  = 3'd5;
   localparam logic [StatusWidth-1:0] ST_FRACTION  = 3'd6;

   localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [31:0] EXP_FIELD = 32'h7f80_0000;
   localparam logic [7:0]  EXP_ONES  = 8'hff;
   localparam logic [4:0]  FRAC_BITS = 5'd23;
   localparam logic [7:0]  EXP_BIAS  = 8'd127;

   typedef struct packed {
      logic [WordWidth-1:0]   word;
      logic [StatusWidth-1:0] status;
      logic                   flag;
   } result_type;

   function automatic result_type encode_int(logic [31:0] v);
      result_type r;
      logic [4:0]  e;
      logic [23:0] sh;
      r = '0;
      e = '0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) e = 5'(i);
      end
      sh = v[23:0] << (FRAC_BITS - e);
      if (v[31:24] != 8'd0) begin
         r.status = ST_TOO_LARGE;
      end else if (v[23:0] != 24'd0) begin
         r.word = {1'b0, 8'({3'd0, e} + EXP_BIAS), sh[22:0]};
      end
      return r;
   endfunction

   function automatic result_type decode_float(logic [31:0] b);
      result_type  r;
      logic [7:0]  ex;
      logic [22:0] frac;
      logic [7:0]  ub;
      logic [4:0]  shamt;
      logic [22:0] mask;
      logic [23:0] mant;
      r     = '0;
      ex    = b[30:23];
      frac  = b[22:0];
      ub    = ex - EXP_BIAS;
      shamt = FRAC_BITS - ub[4:0];
      mask  = (23'd1 << shamt) - 23'd1;
      mant  = {1'b1, frac} >> shamt;
      if (b[31]) begin
         r.status = (ex == 8'd0 && frac == 23'd0) ? ST_NEG_ZERO : ST_NEGATIVE;
      end else if (ex == EXP_ONES) begin
         r.status = ST_NOT_FIN;
      end else if (ex == 8'd0) begin
         r.status = (frac == 23'd0) ? ST_OK : ST_DENORMAL;
      end else if (ex < EXP_BIAS) begin
         r.status = ST_FRACTION;
      end else if (ub > {3'd0, FRAC_BITS}) begin
         r.status = ST_TOO_LARGE;
      end else if ((frac & mask) != 23'd0) begin
         r.status = ST_FRACTION;
      end else begin
         r.word = {8'd0, mant};
      end
      return r;
   endfunction

endpackage

// ===== rtl/exact_int_float_converter.sv =====
// An accepted request is held in the input register; its result enters the result register
// once no result waits or rsp_ready takes it. Int-to-float is a leading-one search and one shift.
// Throughput: one request per cycle while no result waits or rsp_ready takes it.
// A waiting result still lets one new request into the input register, then req_ready drops.
// Reset: synchronous, active high; clears both valid flags, payload registers are not reset.
module exact_int_float_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [eicf_pkg::ModeWidth-1:0]      req_mode,
   input  logic [eicf_pkg::WordWidth-1:0]      req_operand,
   input  logic [eicf_pkg::WordWidth-1:0]      req_limit,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [eicf_pkg::WordWidth-1:0]      rsp_result_word,
   output logic [eicf_pkg::StatusWidth-1:0]    rsp_status,
   output logic                                rsp_test_true
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [eicf_pkg::ModeWidth-1:0]    s1_mode_ff;
   logic [eicf_pkg::WordWidth-1:0]    s1_operand_ff;
   logic [eicf_pkg::WordWidth-1:0]    s1_limit_ff;
   logic                              s1_advance;

   logic                              rsp_valid_ff, rsp_valid_in;
   eicf_pkg::result_type              rsp_ff, rsp_in;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      rsp_in = '0;
      unique case (s1_mode_ff)
         eicf_pkg::MODE_INT_TO_FLOAT: rsp_in = eicf_pkg::encode_int(s1_operand_ff);
         eicf_pkg::MODE_FLOAT_TO_INT: rsp_in = eicf_pkg::decode_float(s1_operand_ff);
         eicf_pkg::MODE_POS_FINITE: begin
            rsp_in.flag = (s1_operand_ff != '0) && (s1_operand_ff != eicf_pkg::SIGN_BIT)
                          && (s1_operand_ff < eicf_pkg::EXP_FIELD);
         end
         eicf_pkg::MODE_RANGE: begin
            rsp_in.flag = !s1_operand_ff[eicf_pkg::WordWidth-1]
                          && (s1_operand_ff <= s1_limit_ff);
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_mode_ff    <= req_mode;
         s1_operand_ff <= req_operand;
         s1_limit_ff   <= req_limit;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_ff.word;
   assign rsp_status      = rsp_ff.status;
   assign rsp_test_true   = rsp_ff.flag;

endmodule

// ===== rtl/eicf_checker.sv =====
`include "exact_int_float_converter_assert.svh"

module eicf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [eicf_pkg::ModeWidth-1:0]   req_mode,
   input logic [eicf_pkg::WordWidth-1:0]   req_operand,
   input logic [eicf_pkg::WordWidth-1:0]   req_limit,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [eicf_pkg::WordWidth-1:0]   rsp_result_word,
   input logic [eicf_pkg::StatusWidth-1:0] rsp_status,
   input logic                             rsp_test_true
);

   `EICF_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   `EICF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result_word) && $stable(rsp_status) && $stable(rsp_test_true))

   `EICF_ASSERT_NOW(a_refusal_zero, clock, reset,
      rsp_valid && (rsp_status != eicf_pkg::ST_OK), rsp_result_word == '0 && !rsp_test_true)

   `EICF_ASSERT_NOW(a_test_clean, clock, reset, rsp_valid && rsp_test_true,
      rsp_result_word == '0 && rsp_status == eicf_pkg::ST_OK)

   `EICF_ASSERT_NEXT(a_accept_moves, clock, reset, req_valid && req_ready, ##1 rsp_valid)

endmodule

bind exact_int_float_converter eicf_checker u_eicf_checker (.*);
